// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the list RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/iidl_pkg.sv =====
// Types and constants for the indexed insert/delete list
package iidl_pkg;

  localparam int DATA_W       = 32;
  localparam int CMD_W        = 3;
  localparam int POS_W        = 4;
  localparam int OUT_CNT_W    = 5;
  localparam int STAT_W       = 2;
  localparam int CAPACITY_DEF = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_READ   = 3'd4
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_INDEX = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  // What every cell does on a clock edge, relative to the broadcast target index
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,  // keep own entry
    CELL_LOAD = 2'd1,  // target cell takes the new value
    CELL_UP   = 2'd2,  // target takes value, cells above take left neighbor
    CELL_DOWN = 2'd3   // target and cells above take right neighbor
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

// ===== hdl/iidl_cell.sv =====
// One list entry cell: holds an entry and trades it with its neighbors
module iidl_cell import iidl_pkg::*; #(
  parameter int CNT_W = 5,
  parameter int INDEX = 0
) (
  input  logic              clk,
  input  cell_ctrl_t        ctrl,
  input  logic [CNT_W-1:0]  target,
  input  logic [DATA_W-1:0] left_data,
  input  logic [DATA_W-1:0] right_data,
  output logic [DATA_W-1:0] data_q
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;
  logic              is_tgt;
  logic              above_tgt;

  assign is_tgt    = (target == MY_IDX);
  assign above_tgt = (MY_IDX > target);

  always_comb begin
    data_nxt = data_r;
    case (ctrl.op)
      CELL_LOAD: begin
        if (is_tgt) data_nxt = ctrl.value;
      end
      CELL_UP: begin
        if (is_tgt) data_nxt = ctrl.value;
        else if (above_tgt) data_nxt = left_data;
      end
      CELL_DOWN: begin
        if (is_tgt || above_tgt) data_nxt = right_data;
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule

// ===== hdl/iidl_ctrl.sv =====
// Command decode, entry count and status for the list
module iidl_ctrl import iidl_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [CMD_W-1:0]  command,
  input  logic [POS_W-1:0]  position,
  input  logic [DATA_W-1:0] item_value,
  output cell_ctrl_t        ctrl,
  output logic [CNT_W-1:0]  target,
  output logic [CNT_W-1:0]  count_q,
  output logic [CNT_W-1:0]  count_next,
  output status_t           status,
  output logic              read_hit
);

  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             idx_ok;
  logic             full;
  logic             empty;
  cell_op_t         op;

  assign idx_ok = CMP_W'(position) < CMP_W'(count_r);
  assign full   = (count_r == CAP_CNT);
  assign empty  = (count_r == '0);

  always_comb begin
    op        = CELL_HOLD;
    target    = CNT_W'(position);
    count_nxt = count_r;
    status    = ST_OK;
    read_hit  = 1'b0;
    unique case (cmd_t'(command))
      CMD_PUSH: begin
        target = count_r;
        if (full) status = ST_FULL;
        else begin
          op        = CELL_LOAD;
          count_nxt = count_r + ONE;
        end
      end
      CMD_POP: begin
        if (empty) status = ST_EMPTY;
        else count_nxt = count_r - ONE;
      end
      CMD_INSERT: begin
        if (!idx_ok) status = ST_BAD_INDEX;
        else if (full) status = ST_FULL;
        else begin
          op        = CELL_UP;
          count_nxt = count_r + ONE;
        end
      end
      CMD_REMOVE: begin
        if (!idx_ok) status = ST_BAD_INDEX;
        else begin
          op        = CELL_DOWN;
          count_nxt = count_r - ONE;
        end
      end
      CMD_READ: begin
        if (!idx_ok) status = ST_BAD_INDEX;
        else read_hit = 1'b1;
      end
      default: status = ST_BAD_INDEX;
    endcase
    // idle cycles leave the cells alone
    if (!accept) op = CELL_HOLD;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
    end
  end

  assign ctrl.op    = op;
  assign ctrl.value = item_value;
  assign count_q    = count_r;
  assign count_next = count_nxt;

endmodule

// ===== hdl/indexed_insert_delete_list_top.sv =====
// Top level of the indexed insert/delete list
//
// An ordered list of up to CAPACITY signed 32-bit entries held in a row of
// cells; insert and remove shift every entry above the index in one step.
// A command is taken at any clock edge with start high (busy stays low), so
// one command completes per cycle, and its result appears on the out_ ports
// with out_valid high for exactly one cycle, the cycle after the transfer.
// The receiver cannot stall: capture each result while out_valid is high.
// entry_count shows the count modulo 32; position reaches indexes 0 to 15.
`include "assert_macros.svh"

module indexed_insert_delete_list_top import iidl_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [CMD_W-1:0]            in_command,
  input  logic [POS_W-1:0]            in_position,
  input  logic signed [DATA_W-1:0]    in_item_value,
  output logic                        out_valid,
  output logic signed [DATA_W-1:0]    out_read_data,
  output logic [OUT_CNT_W-1:0]        out_entry_count,
  output logic [STAT_W-1:0]           out_status
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int RD_N  = (CAPACITY < (1 << POS_W)) ? CAPACITY : (1 << POS_W);
  localparam int RD_W  = $clog2(RD_N);

  logic                     accept;
  cell_ctrl_t               ctrl;
  logic [CNT_W-1:0]         target;
  logic [CNT_W-1:0]         count_q;
  logic [CNT_W-1:0]         count_next;
  status_t                  status;
  logic                     read_hit;
  logic [DATA_W-1:0]        entry_q [CAPACITY];
  logic [DATA_W-1:0]        rd_view [RD_N];
  logic [DATA_W-1:0]        rd_word;

  logic                     valid_r;
  logic [DATA_W-1:0]        rdata_r;
  logic [OUT_CNT_W-1:0]     ecount_r;
  logic [STAT_W-1:0]        status_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  iidl_ctrl #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .command    (in_command),
    .position   (in_position),
    .item_value (in_item_value),
    .ctrl       (ctrl),
    .target     (target),
    .count_q    (count_q),
    .count_next (count_next),
    .status     (status),
    .read_hit   (read_hit)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_d;
    logic [DATA_W-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = ctrl.value;
    end else begin : g_mid_l
      assign left_d = entry_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = entry_q[i];
    end else begin : g_mid_r
      assign right_d = entry_q[i+1];
    end
    iidl_cell #(
      .CNT_W (CNT_W),
      .INDEX (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .target     (target),
      .left_data  (left_d),
      .right_data (right_d),
      .data_q     (entry_q[i])
    );
  end

  // only the low entries are reachable through the position field
  for (genvar j = 0; j < RD_N; j++) begin : g_rd
    assign rd_view[j] = entry_q[j];
  end
  assign rd_word = rd_view[in_position[RD_W-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rdata_r  <= read_hit ? rd_word : '0;
      ecount_r <= OUT_CNT_W'(count_next);
      status_r <= status;
    end
  end

  assign out_valid       = valid_r;
  assign out_read_data   = rdata_r;
  assign out_entry_count = ecount_r;
  assign out_status      = status_r;

  `ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CNT_W'(CAPACITY))
  `ASSERT_NEXT(a_count_idle, !accept, $stable(count_q))
  `ASSERT_NEXT(a_strobe, accept, out_valid)
  `ASSERT_IMPL(a_full_count, out_valid && out_status == ST_FULL,
               out_entry_count == OUT_CNT_W'(CAPACITY))
  `ASSERT_IMPL(a_rdata_ok, out_valid && out_read_data != '0, out_status == ST_OK)

endmodule

// ===== tb/sv/tb_indexed_insert_delete_list_top.sv =====
// Self-checking testbench for the indexed insert/delete list
module tb_indexed_insert_delete_list_top;
  import iidl_pkg::*;

  localparam int CAPACITY     = CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 1250;
  localparam int TAIL_ITEMS   = 200;
  localparam int STALL_LIMIT  = 2000;
  localparam int NUM_ROWS     = 25;
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = CMD_W'(CMD_READ + 1);
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = '1;

  typedef struct packed {
    logic signed [DATA_W-1:0] rd;
    logic [OUT_CNT_W-1:0]     cnt;
    status_t                  st;
  } list_result_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] val;
    logic [4:0]        rep;
    bit                typed;
    list_result_t      want;
  } dir_row_t;

  logic                     clk;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [CMD_W-1:0]         in_command = '0;
  logic [POS_W-1:0]         in_position = '0;
  logic signed [DATA_W-1:0] in_item_value = '0;
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_read_data;
  logic [OUT_CNT_W-1:0]     out_entry_count;
  logic [STAT_W-1:0]        out_status;

  logic signed [DATA_W-1:0] model_entries [CAPACITY];
  int                       model_count = 0;
  list_result_t             expected_results [$];
  int                       mismatch_count = 0;
  int                       stall_cycles = 0;
  bit                       gap_phase = 1'b1;

  // Rows with typed = 0 take their expectation from the list model
  dir_row_t directed_rows [NUM_ROWS] = '{
    '{CMD_POP,       4'd0,  32'h0000_0000, 5'd1,  1'b1, '{32'h0, 5'd0,  ST_EMPTY}},
    '{CMD_READ,      4'd0,  32'h0000_0000, 5'd1,  1'b1, '{32'h0, 5'd0,  ST_BAD_INDEX}},
    '{CMD_INSERT,    4'd0,  32'h0000_0005, 5'd1,  1'b1, '{32'h0, 5'd0,  ST_BAD_INDEX}},
    '{CMD_REMOVE,    4'd15, 32'h0000_0000, 5'd1,  1'b1, '{32'h0, 5'd0,  ST_BAD_INDEX}},
    '{CMD_PUSH,      4'd0,  32'h8000_0000, 5'd1,  1'b1, '{32'h0, 5'd1,  ST_OK}},
    '{CMD_PUSH,      4'd9,  32'h7FFF_FFFF, 5'd1,  1'b1, '{32'h0, 5'd2,  ST_OK}},
    '{CMD_READ,      4'd0,  32'h0000_0000, 5'd1,  1'b1, '{32'h8000_0000, 5'd2, ST_OK}},
    '{CMD_READ,      4'd1,  32'h0000_0000, 5'd1,  1'b1, '{32'h7FFF_FFFF, 5'd2, ST_OK}},
    '{CMD_READ,      4'd2,  32'h0000_0000, 5'd1,  1'b1, '{32'h0, 5'd2,  ST_BAD_INDEX}},
    '{CMD_INSERT,    4'd0,  32'hFFFF_FFFF, 5'd1,  1'b0, '{32'h0, 5'd0,  ST_OK}},
    '{CMD_INSERT,    4'd1,  32'h1234_5678, 5'd1,  1'b0, '{32'h0, 5'd0,  ST_OK}},
    '{CMD_READ,      4'd0,  32'h0000_0000, 5'd1,  1'b0, '{32'h0, 5'd0,  ST_OK}},
    '{CMD_REMOVE,    4'd0,  32'h0000_0000, 5'd1,  1'b0, '{32'h0, 5'd0,  ST_OK}},
    '{CMD_UNUSED_LO, 4'd0,  32'h0000_0000, 5'd1,  1'b0, '{32'h0, 5'd0,  ST_OK}},
    '{CMD_UNUSED_HI, 4'd15, 32'hFFFF_FFFF, 5'd1,  1'b0, '{32'h0, 5'd0,  ST_OK}},
    '{CMD_PUSH,      4'd0,  32'h0000_1000, 5'd13, 1'b0, '{32'h0, 5'd0,  ST_OK}},
    '{CMD_PUSH,      4'd0,  32'h0000_0BAD, 5'd1,  1'b1, '{32'h0, 5'd16, ST_FULL}},
    '{CMD_INSERT,    4'd15, 32'h0000_0BAD, 5'd1,  1'b1, '{32'h0, 5'd16, ST_FULL}},
    '{CMD_INSERT,    4'd0,  32'h0000_0BAD, 5'd1,  1'b1, '{32'h0, 5'd16, ST_FULL}},
    '{CMD_READ,      4'd15, 32'h0000_0000, 5'd1,  1'b0, '{32'h0, 5'd0,  ST_OK}},
    '{CMD_REMOVE,    4'd15, 32'h0000_0000, 5'd1,  1'b0, '{32'h0, 5'd0,  ST_OK}},
    '{CMD_INSERT,    4'd14, 32'h0000_0000, 5'd1,  1'b0, '{32'h0, 5'd0,  ST_OK}},
    '{CMD_REMOVE,    4'd0,  32'h0000_0000, 5'd1,  1'b0, '{32'h0, 5'd0,  ST_OK}},
    '{CMD_POP,       4'd0,  32'h0000_0000, 5'd15, 1'b0, '{32'h0, 5'd0,  ST_OK}},
    '{CMD_POP,       4'd0,  32'h0000_0000, 5'd1,  1'b1, '{32'h0, 5'd0,  ST_EMPTY}}
  };

  indexed_insert_delete_list_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_position     (in_position),
    .in_item_value   (in_item_value),
    .out_valid       (out_valid),
    .out_read_data   (out_read_data),
    .out_entry_count (out_entry_count),
    .out_status      (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Apply one command to the list model and return the result it gives
  function automatic list_result_t apply_list_command(logic [CMD_W-1:0] cmd,
                                                      logic [POS_W-1:0] pos,
                                                      logic signed [DATA_W-1:0] val);
    list_result_t res;
    int           i;
    res = '{rd: '0, cnt: '0, st: ST_OK};
    case (cmd)
      CMD_PUSH: begin
        if (model_count >= CAPACITY) begin
          res.st = ST_FULL;
        end else begin
          model_entries[model_count] = val;
          model_count++;
        end
      end
      CMD_POP: begin
        if (model_count == 0) res.st = ST_EMPTY;
        else model_count--;
      end
      CMD_INSERT: begin
        // index check wins over the full check
        if (int'(pos) >= model_count) begin
          res.st = ST_BAD_INDEX;
        end else if (model_count >= CAPACITY) begin
          res.st = ST_FULL;
        end else begin
          for (i = model_count; i > int'(pos); i--) model_entries[i] = model_entries[i-1];
          model_entries[pos] = val;
          model_count++;
        end
      end
      CMD_REMOVE: begin
        if (int'(pos) >= model_count) begin
          res.st = ST_BAD_INDEX;
        end else begin
          for (i = int'(pos); i + 1 < model_count; i++) model_entries[i] = model_entries[i+1];
          model_count--;
        end
      end
      CMD_READ: begin
        if (int'(pos) >= model_count) res.st = ST_BAD_INDEX;
        else res.rd = model_entries[pos];
      end
      default: res.st = ST_BAD_INDEX;
    endcase
    res.cnt = OUT_CNT_W'(model_count);
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                 logic [DATA_W-1:0] want);
    $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
    mismatch_count++;
  endtask

  // Drive one command, hold it until the transfer, then queue its expectation
  task automatic issue_command(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                               logic [DATA_W-1:0] val, bit typed,
                               list_result_t want, bit allow_gap);
    list_result_t predicted;
    in_command    <= cmd;
    in_position   <= pos;
    in_item_value <= val;
    start         <= 1'b1;
    do @(posedge clk); while (busy);
    predicted = apply_list_command(cmd, pos, val);
    expected_results.push_back(typed ? want : predicted);
    if (allow_gap && $urandom_range(3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(16, 1)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing outstanding", out_read_data, '0);
      end else begin
        want = expected_results.pop_front();
        if (out_read_data !== want.rd)
          report_mismatch("read_data", out_read_data, want.rd);
        if (out_entry_count !== want.cnt)
          report_mismatch("entry_count", DATA_W'(out_entry_count), DATA_W'(want.cnt));
        if (out_status !== want.st)
          report_mismatch("status", DATA_W'(out_status), DATA_W'(want.st));
      end
    end
  end

  // End the run when nothing transfers for too long
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int                       r;
    int                       k;
    bit                       growing;
    bit                       tail;
    logic [CMD_W-1:0]         cmd;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] val;
    growing = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[n]) begin
      for (k = 0; k < int'(directed_rows[n].rep); k++)
        issue_command(directed_rows[n].cmd, directed_rows[n].pos,
                      directed_rows[n].val + DATA_W'(k), directed_rows[n].typed,
                      directed_rows[n].want, gap_phase);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      tail = (n >= RANDOM_ITEMS - TAIL_ITEMS);
      if (n % 64 == 0) gap_phase = ($urandom_range(2) != 0);
      // sweep the fill level between empty and full
      if (model_count >= CAPACITY) growing = 1'b0;
      else if (model_count == 0) growing = 1'b1;
      else if ($urandom_range(40) == 0) growing = !growing;

      r = $urandom_range(99);
      if (r < 3) cmd = CMD_W'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
      else if (r < 28) cmd = CMD_READ;
      else if (r < 62) cmd = growing ? CMD_PUSH : CMD_POP;
      else if (r < 82) cmd = growing ? CMD_INSERT : CMD_REMOVE;
      else if (r < 91) cmd = growing ? CMD_REMOVE : CMD_INSERT;
      else cmd = growing ? CMD_POP : CMD_PUSH;

      if (model_count > 0 && $urandom_range(99) < 85)
        pos = POS_W'($urandom_range(model_count - 1));
      else
        pos = POS_W'($urandom_range(15));

      if ($urandom_range(9) == 0) begin
        case ($urandom_range(3))
          0: val = 32'sh8000_0000;
          1: val = 32'sh7FFF_FFFF;
          2: val = '0;
          default: val = '1;
        endcase
      end else begin
        val = $urandom;
      end

      issue_command(cmd, pos, val, 1'b0, '0, gap_phase && !tail);
    end
    start <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
